// ===== rtl/core/fqs_pkg.sv =====
// package for the fastq record quality scanner: types, constants
`default_nettype none
package fqs_pkg;

  localparam int unsigned LenW      = 16;
  localparam int unsigned CntW      = 24;
  localparam int unsigned TotW      = 40;
  localparam int unsigned CtrW      = 17;
  localparam int unsigned QDepth    = 2;
  localparam logic [CtrW-1:0] SeqLimit = CtrW'(65535 + 3);
  localparam logic [7:0] ThreshReset = 8'd66;
  localparam logic [7:0] ChAt   = 8'h40;
  localparam logic [7:0] ChNl   = 8'h0a;
  localparam logic [7:0] ChPlus = 8'h2b;

  typedef enum logic [2:0] {
    KindRecord  = 3'd0,
    KindSummary = 3'd1,
    KindNoAt    = 3'd2,
    KindNoNl    = 3'd3,
    KindTooLong = 3'd4,
    KindTrunc   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    PhSeek = 3'd0,
    PhId   = 3'd1,
    PhSeq  = 3'd2,
    PhQual = 3'd3,
    PhNl   = 3'd4,
    PhErr  = 3'd5
  } phase_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [LenW-1:0] seq_length;
    logic [LenW-1:0] run_start;
    logic [LenW-1:0] run_length;
    logic [1:0]      crossings;
    logic [CntW-1:0] record_count;
    logic [TotW-1:0] total_bases;
    logic [TotW-1:0] total_run_bases;
    logic [LenW-1:0] min_length;
    logic [LenW-1:0] max_length;
    logic [7:0]      min_quality;
    logic [7:0]      max_quality;
  } out_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic       cmd;
    logic       is_at;
    logic       is_nl;
    logic       is_plus;
    logic       ge_thr;
    logic [7:0] data_byte;
  } tok_t;

endpackage
`default_nettype wire

// ===== rtl/core/fqs_front.sv =====
// front end: takes bytes, classifies them, queues them for the back end
`default_nettype none
module fqs_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire fqs_pkg::in_t  in_i,
  input  wire logic          push,
  output logic               full,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_data_i,
  output fqs_pkg::tok_t      tok_o,
  output logic               tok_valid_o,
  input  wire logic          tok_take_i
);
  import fqs_pkg::*;

  logic [7:0]  thr_q;
  tok_t        mem_q [QDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        wr, rd;
  tok_t        t;

  assign full        = (cnt_q == 2'(QDepth));
  assign wr          = push & ~full;
  assign tok_valid_o = (cnt_q != 2'd0);
  assign rd          = tok_take_i & tok_valid_o;
  assign tok_o       = mem_q[rp_q];

  always_comb begin
    t.cmd       = in_i.cmd;
    t.data_byte = in_i.data_byte;
    t.is_at     = (in_i.data_byte == ChAt);
    t.is_nl     = (in_i.data_byte == ChNl);
    t.is_plus   = (in_i.data_byte == ChPlus);
    t.ge_thr    = (in_i.data_byte >= thr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThreshReset;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_data_i;
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= t;
  end

endmodule
`default_nettype wire

// ===== rtl/core/fqs_back.sv =====
// back end: record parser, statistics and result register
`default_nettype none
module fqs_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire fqs_pkg::tok_t tok_i,
  input  wire logic          tok_valid_i,
  output logic               tok_take_o,
  output fqs_pkg::out_t      out_o,
  output logic               empty,
  input  wire logic          pop
);
  import fqs_pkg::*;

  phase_e          ph_q, ph_d;
  logic [15:0]     win_q, win_d;
  logic [CtrW-1:0] bc_q, bc_d;
  logic [LenW-1:0] rl_q, rl_d;
  logic [1:0]      rp_q, rp_d;
  logic [LenW-1:0] rs_q, rs_d, rn_q, rn_d;
  logic [CntW-1:0] rc_q, rc_d;
  logic [TotW-1:0] tb_q, tb_d, tr_q, tr_d;
  logic [LenW-1:0] mn_q, mn_d, mx_q, mx_d;
  logic [7:0]      lq_q, lq_d, hq_q, hq_d;
  out_t            res_q, res_d;
  logic            full_q, emit;
  logic            fin;
  kind_e           kd;
  logic [TotW:0]   sb, sr;
  logic [LenW-1:0] runlen;

  // result slot frees when popped, so a new byte can enter the same cycle
  assign tok_take_o = tok_valid_i & (~full_q | pop);
  assign empty      = ~full_q;
  assign out_o      = res_q;

  always_comb begin
    ph_d = ph_q; win_d = win_q; bc_d = bc_q; rl_d = rl_q; rp_d = rp_q;
    rs_d = rs_q; rn_d = rn_q; rc_d = rc_q; tb_d = tb_q; tr_d = tr_q;
    mn_d = mn_q; mx_d = mx_q; lq_d = lq_q; hq_d = hq_q;
    emit = 1'b0; fin = 1'b0; kd = KindRecord;
    sb = '0; sr = '0; runlen = '0;
    if (tok_i.cmd) begin
      emit = 1'b1;
      kd = (ph_q == PhId || ph_q == PhSeq || ph_q == PhQual) ? KindTrunc : KindSummary;
    end else begin
      unique case (ph_q)
        PhSeek: begin
          if (tok_i.is_at) ph_d = PhId;
          else if (tok_i.is_nl) begin
            emit = 1'b1; kd = KindNoAt; ph_d = PhErr;
          end
        end
        PhId: begin
          if (tok_i.is_nl) begin
            ph_d = PhSeq; win_d = '0; bc_d = '0;
          end
        end
        PhSeq: begin
          if (bc_q >= CtrW'(2) && win_q[15:8] == ChNl && win_q[7:0] == ChPlus
              && tok_i.is_nl) begin
            rl_d = LenW'(bc_q - CtrW'(2));
            bc_d = '0; rp_d = '0; rs_d = '0; rn_d = '0;
            if (bc_q == CtrW'(2)) fin = 1'b1;
            else ph_d = PhQual;
          end else begin
            win_d = {win_q[7:0], tok_i.data_byte};
            bc_d  = bc_q + CtrW'(1);
            if (bc_d >= SeqLimit) begin
              emit = 1'b1; kd = KindTooLong; ph_d = PhErr;
            end
          end
        end
        PhQual: begin
          if (tok_i.data_byte > hq_q) hq_d = tok_i.data_byte;
          if (tok_i.data_byte < lq_q) lq_d = tok_i.data_byte;
          if (tok_i.ge_thr) begin
            if (rp_q == 2'd0) begin
              rp_d = 2'd1; rs_d = LenW'(bc_q); rn_d = LenW'(1);
            end else if (rp_q == 2'd1) rn_d = rn_q + LenW'(1);
          end else if (rp_q == 2'd1) rp_d = 2'd2;
          bc_d = bc_q + CtrW'(1);
          if (bc_d >= CtrW'(rl_q)) fin = 1'b1;
        end
        PhNl: begin
          if (tok_i.is_nl) ph_d = PhSeek;
          else begin
            emit = 1'b1; kd = KindNoNl; ph_d = PhErr;
          end
        end
        default: ;
      endcase
    end
    if (fin) begin
      emit = 1'b1; kd = KindRecord; ph_d = PhNl;
      runlen = (rp_d != 2'd0) ? rn_d : '0;
      if (rc_q != '1) rc_d = rc_q + CntW'(1);
      sb = {1'b0, tb_q} + (TotW+1)'(rl_d);
      sr = {1'b0, tr_q} + (TotW+1)'(runlen);
      tb_d = sb[TotW] ? '1 : sb[TotW-1:0];
      tr_d = sr[TotW] ? '1 : sr[TotW-1:0];
      if (rl_d < mn_q) mn_d = rl_d;
      if (rl_d > mx_q) mx_d = rl_d;
    end
    res_d.kind            = kd;
    res_d.seq_length      = fin ? rl_d : '0;
    res_d.run_start       = (fin && rp_d != 2'd0) ? rs_d : '0;
    res_d.run_length      = runlen;
    res_d.crossings       = fin ? rp_d : '0;
    res_d.record_count    = rc_d;
    res_d.total_bases     = tb_d;
    res_d.total_run_bases = tr_d;
    res_d.min_length      = mn_d;
    res_d.max_length      = mx_d;
    res_d.min_quality     = lq_d;
    res_d.max_quality     = hq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhSeek; win_q <= '0; bc_q <= '0; rl_q <= '0; rp_q <= '0;
      rs_q <= '0; rn_q <= '0; rc_q <= '0; tb_q <= '0; tr_q <= '0;
      mn_q <= '1; mx_q <= '0; lq_q <= 8'd127; hq_q <= '0;
      full_q <= 1'b0;
    end else begin
      if (pop && full_q) full_q <= 1'b0;
      if (tok_take_o) begin
        if (emit) full_q <= 1'b1;
        if (tok_i.cmd) begin
          ph_q <= PhSeek; win_q <= '0; bc_q <= '0; rl_q <= '0; rp_q <= '0;
          rs_q <= '0; rn_q <= '0; rc_q <= '0; tb_q <= '0; tr_q <= '0;
          mn_q <= '1; mx_q <= '0; lq_q <= 8'd127; hq_q <= '0;
        end else begin
          ph_q <= ph_d; win_q <= win_d; bc_q <= bc_d; rl_q <= rl_d; rp_q <= rp_d;
          rs_q <= rs_d; rn_q <= rn_d; rc_q <= rc_d; tb_q <= tb_d; tr_q <= tr_d;
          mn_q <= mn_d; mx_q <= mx_d; lq_q <= lq_d; hq_q <= hq_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_take_o && emit) res_q <= res_d;
  end

endmodule
`default_nettype wire

// ===== rtl/core/fastq_record_quality_scanner.sv =====
// top level of the fastq record quality scanner
//  channel   | signals                      | accepted when
//  input     | push, full, in_i             | push && !full
//  result    | empty, pop, out_o            | pop && !empty
//  config    | cfg_we_i, cfg_data_i         | cfg_we_i
// one byte per cycle sustained while results are popped; a word runs through a
// two-entry queue and one parser stage that writes the result register.
// the parser stalls only while its result register is full and not popped.
// reset clears queue, parser and totals; threshold returns to 66.
`default_nettype none
module fastq_record_quality_scanner (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire fqs_pkg::in_t  in_i,
  input  wire logic          push,
  output logic               full,
  output fqs_pkg::out_t      out_o,
  output logic               empty,
  input  wire logic          pop,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_data_i
);
  import fqs_pkg::*;

  tok_t tok;
  logic tok_valid, tok_take;

  fqs_front u_front (
    .clk_i, .rst_ni, .in_i, .push, .full, .cfg_we_i, .cfg_data_i,
    .tok_o(tok), .tok_valid_o(tok_valid), .tok_take_i(tok_take)
  );

  fqs_back u_back (
    .clk_i, .rst_ni, .tok_i(tok), .tok_valid_i(tok_valid), .tok_take_o(tok_take),
    .out_o, .empty, .pop
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// testbench for the fastq record quality scanner: directed and random byte streams
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fqs_pkg::*;

  localparam int unsigned WatchLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  in_t in_i = '0;
  logic push = 1'b0;
  logic full;
  out_t out_o;
  logic empty;
  logic pop = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_data_i = '0;

  fastq_record_quality_scanner dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_i), .push(push), .full(full),
    .out_o(out_o), .empty(empty), .pop(pop), .cfg_we_i(cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state
  logic [7:0] threshold;
  phase_e ph;
  logic [15:0] win;
  int unsigned count;
  int unsigned read_len;
  logic [1:0] run_ph;
  logic [15:0] run_first;
  logic [15:0] run_len;
  logic [23:0] recs;
  logic [39:0] bases;
  logic [39:0] run_bases;
  logic [15:0] shortest;
  logic [15:0] longest;
  logic [7:0] low_q;
  logic [7:0] high_q;

  out_t expected_words[$];
  int unsigned errors = 0;
  int unsigned records_seen = 0;
  int unsigned words_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_off = 0;
  bit random_pop_gaps = 1'b1;

  function automatic logic [39:0] add_sat40(logic [39:0] s, int unsigned a);
    logic [40:0] t;
    t = {1'b0, s} + 41'(a);
    return t[40] ? 40'hFF_FFFF_FFFF : t[39:0];
  endfunction

  function automatic logic [15:0] sat16(int unsigned v);
    return v > 65535 ? 16'hFFFF : v[15:0];
  endfunction

  function automatic void clear_stream();
    ph = PhSeek; win = '0; count = 0; read_len = 0;
    run_ph = '0; run_first = '0; run_len = '0;
    recs = '0; bases = '0; run_bases = '0;
    shortest = 16'hFFFF; longest = '0; low_q = 8'd127; high_q = '0;
  endfunction

  function automatic void queue_word(kind_e k, bit rec);
    out_t o;
    o.kind = k;
    o.seq_length = rec ? sat16(read_len) : '0;
    o.run_start = (rec && run_ph != 0) ? run_first : '0;
    o.run_length = (rec && run_ph != 0) ? run_len : '0;
    o.crossings = rec ? run_ph : '0;
    o.record_count = recs;
    o.total_bases = bases;
    o.total_run_bases = run_bases;
    o.min_length = shortest;
    o.max_length = longest;
    o.min_quality = low_q;
    o.max_quality = high_q;
    expected_words.push_back(o);
  endfunction

  function automatic void close_record();
    logic [15:0] l16;
    l16 = sat16(read_len);
    if (recs != 24'hFF_FFFF) recs++;
    bases = add_sat40(bases, read_len);
    run_bases = add_sat40(run_bases, run_ph != 0 ? int'(run_len) : 0);
    if (l16 < shortest) shortest = l16;
    if (l16 > longest) longest = l16;
    queue_word(KindRecord, 1'b1);
    ph = PhNl;
  endfunction

  function automatic void predict_scan(in_t w);
    logic [7:0] b;
    b = w.data_byte;
    if (w.cmd) begin
      queue_word((ph == PhId || ph == PhSeq || ph == PhQual) ? KindTrunc : KindSummary,
                 1'b0);
      clear_stream();
      return;
    end
    case (ph)
      PhSeek: begin
        if (b == ChAt) ph = PhId;
        else if (b == ChNl) begin
          queue_word(KindNoAt, 1'b0);
          ph = PhErr;
        end
      end
      PhId: begin
        if (b == ChNl) begin
          ph = PhSeq; win = '0; count = 0;
        end
      end
      PhSeq: begin
        if (count >= 2 && win[15:8] == ChNl && win[7:0] == ChPlus && b == ChNl) begin
          read_len = count - 2;
          count = 0;
          run_ph = '0; run_first = '0; run_len = '0;
          if (read_len == 0) close_record();
          else ph = PhQual;
        end else begin
          win = {win[7:0], b};
          count++;
          if (count >= 65535 + 3) begin
            queue_word(KindTooLong, 1'b0);
            ph = PhErr;
          end
        end
      end
      PhQual: begin
        if (b > high_q) high_q = b;
        if (b < low_q) low_q = b;
        if (b >= threshold) begin
          if (run_ph == 0) begin
            run_ph = 2'd1; run_first = count[15:0]; run_len = 16'd1;
          end else if (run_ph == 1) begin
            run_len++;
          end
        end else if (run_ph == 1) begin
          run_ph = 2'd2;
        end
        count++;
        if (count >= read_len) close_record();
      end
      PhNl: begin
        if (b == ChNl) ph = PhSeek;
        else begin
          queue_word(KindNoNl, 1'b0);
          ph = PhErr;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // sender: push stays high across back-to-back words
  task automatic send_word(bit cmd, logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= '{cmd: cmd, data_byte: b};
    do @(posedge clk_i); while (full);
    predict_scan('{cmd: cmd, data_byte: b});
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_word(1'b0, s[i]);
  endtask

  task automatic end_stream();
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [7:0] t);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= t;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold = t;
  endtask

  // one record with quality bytes drawn around the threshold
  task automatic send_record(int unsigned len, bit good_tail);
    string nuc;
    nuc = "ACGTN";
    send_word(1'b0, ChAt);
    repeat ($urandom_range(0, 3)) send_word(1'b0, 8'($urandom_range(8'h21, 8'h7e)));
    send_word(1'b0, ChNl);
    repeat (len) send_word(1'b0, nuc[$urandom_range(0, 4)]);
    send_text("\n+\n");
    repeat (len) send_word(1'b0, 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                    : $urandom_range(8'h21, 8'h4a)));
    if (good_tail) send_word(1'b0, ChNl);
  endtask

  // results
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && pop && !empty) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("unexpected result word kind %0d at %0t", out_o.kind, $realtime);
      end else begin
        e = expected_words.pop_front();
        if (out_o.kind == KindRecord) records_seen++;
        if (out_o.kind != e.kind) report_mismatch("kind", out_o.kind, e.kind);
        if (out_o.seq_length != e.seq_length)
          report_mismatch("seq_length", out_o.seq_length, e.seq_length);
        if (out_o.run_start != e.run_start)
          report_mismatch("run_start", out_o.run_start, e.run_start);
        if (out_o.run_length != e.run_length)
          report_mismatch("run_length", out_o.run_length, e.run_length);
        if (out_o.crossings != e.crossings)
          report_mismatch("crossings", out_o.crossings, e.crossings);
        if (out_o.record_count != e.record_count)
          report_mismatch("record_count", out_o.record_count, e.record_count);
        if (out_o.total_bases != e.total_bases)
          report_mismatch("total_bases", out_o.total_bases, e.total_bases);
        if (out_o.total_run_bases != e.total_run_bases)
          report_mismatch("total_run_bases", out_o.total_run_bases, e.total_run_bases);
        if (out_o.min_length != e.min_length)
          report_mismatch("min_length", out_o.min_length, e.min_length);
        if (out_o.max_length != e.max_length)
          report_mismatch("max_length", out_o.max_length, e.max_length);
        if (out_o.min_quality != e.min_quality)
          report_mismatch("min_quality", out_o.min_quality, e.min_quality);
        if (out_o.max_quality != e.max_quality)
          report_mismatch("max_quality", out_o.max_quality, e.max_quality);
      end
    end
  end

  // receiver stalls, with one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) pop <= 1'b0;
    else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else if (random_pop_gaps) pop <= ($urandom_range(0, 3) == 0);
    else pop <= 1'b1;
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_text("junk@id\nACGT\n+\n");
    send_word(1'b0, 8'd0);
    send_word(1'b0, 8'd255);
    send_word(1'b0, 8'h21);
    send_word(1'b0, 8'h7e);
    send_word(1'b0, ChNl);
    send_text("@\n\n+\n\n");        // empty read
    end_stream();                    // summary
    send_text("xx\n");               // newline before header
    send_text("@a");                 // ignored while in error
    end_stream();
    send_text("@r\nAC\n+\nBBX");     // missing newline after qualities
    end_stream();
    send_text("@r\nACG");            // truncated record
    end_stream();
    end_stream();                    // summary with nothing seen
  endtask

  task automatic test_thresholds();
    logic [7:0] thr_list [4];
    thr_list = '{8'd0, 8'd255, 8'd66, 8'd40};
    foreach (thr_list[i]) begin
      set_threshold(thr_list[i]);
      send_record(3, 1'b1);
      send_record(2, 1'b1);
      end_stream();
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_off = 300;
    repeat (10) send_record(1, 1'b1);
    end_stream();
    drain();  // sender pauses until all results are in
  endtask

  task automatic test_random();
    int unsigned r;
    set_threshold(8'($urandom_range(0, 255)));
    for (int n = 0; n < 16; n++) begin
      r = $urandom_range(0, 19);
      if (r < 14) send_record($urandom_range(0, 6), 1'b1);
      else if (r < 16) send_record($urandom_range(1, 4), 1'b0);
      else if (r < 18) send_word(1'b0, 8'($urandom_range(0, 255)));
      else end_stream();
      if (n % 8 == 7) begin
        random_pop_gaps = (n != 7);
        end_stream();
        set_threshold(8'($urandom_range(0, 255)));
      end
    end
    end_stream();
  endtask

  initial begin
    threshold = ThreshReset;
    clear_stream();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_thresholds();
    test_backpressure();
    test_random();
    drain();
    $display("checked %0d result words, %0d records, thresholds 0 to 255,",
             words_seen, records_seen);
    $display("header, newline and truncation errors, and long result stalls");
    if (errors == 0 && expected_words.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
